/* design/utf8_decoder_xml_classifier_assert.svh */
// Assertion macros shared by the UTF-8 decoder and XML classifier.
`ifndef UTF8_DECODER_XML_CLASSIFIER_ASSERT_SVH
`define UTF8_DECODER_XML_CLASSIFIER_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define U8XML_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define U8XML_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/u8xml_pkg.sv */
// Shared types, constants and the XML character class function.
`timescale 1ns / 1ps
package u8xml_pkg;

  localparam int unsigned CpW        = 21;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  localparam logic [CpW-1:0] CpRepl    = 21'h00FFFD;
  localparam logic [CpW-1:0] CpMax     = 21'h10FFFF;
  localparam logic [CpW-1:0] CpSurLo   = 21'h00D800;
  localparam logic [CpW-1:0] CpSurHi   = 21'h00DFFF;
  localparam logic [CpW-1:0] CpMin2    = 21'h000080;
  localparam logic [CpW-1:0] CpMin3    = 21'h000800;
  localparam logic [CpW-1:0] CpMin4    = 21'h010000;
  localparam logic [CpW-1:0] CpNameMax = 21'h0EFFFF;

  // One word of work handed from the front to the back: a run of
  // single-byte replacements, then optionally one final result.
  typedef struct packed {
    logic [1:0]     n_repl;
    logic           has_tail;
    logic [CpW-1:0] tail_cp;
    logic           tail_ok;
    logic [2:0]     tail_used;
  } job_t;

  typedef struct packed {
    logic is_char;
    logic start;
    logic name;
  } xml_class_t;

  function automatic logic in_rng(logic [CpW-1:0] c, logic [CpW-1:0] lo,
                                  logic [CpW-1:0] hi);
    in_rng = (c >= lo) && (c <= hi);
  endfunction

  function automatic xml_class_t classify(logic [CpW-1:0] c);
    xml_class_t r;
    r.is_char = (c == 21'h9) || (c == 21'hA) || (c == 21'hD) ||
                in_rng(c, 21'h20, 21'hD7FF) || in_rng(c, 21'hE000, 21'hFFFD) ||
                in_rng(c, CpMin4, CpMax);
    r.start = (c == 21'h3A) || (c == 21'h5F) || in_rng(c, 21'h41, 21'h5A) ||
              in_rng(c, 21'h61, 21'h7A) || in_rng(c, 21'hC0, 21'hD6) ||
              in_rng(c, 21'hD8, 21'hF6) || in_rng(c, 21'hF8, 21'h2FF) ||
              in_rng(c, 21'h370, 21'h37D) || in_rng(c, 21'h37F, 21'h1FFF) ||
              in_rng(c, 21'h200C, 21'h200D) || in_rng(c, 21'h2070, 21'h218F) ||
              in_rng(c, 21'h2C00, 21'h2FEF) || in_rng(c, 21'h3001, 21'hD7FF) ||
              in_rng(c, 21'hF900, 21'hFDCF) || in_rng(c, 21'hFDF0, 21'hFFFD) ||
              in_rng(c, CpMin4, CpNameMax);
    r.name = r.start || (c == 21'h2D) || (c == 21'h2E) || in_rng(c, 21'h30, 21'h39) ||
             (c == 21'hB7) || in_rng(c, 21'h300, 21'h36F) ||
             in_rng(c, 21'h203F, 21'h2040);
    return r;
  endfunction

endpackage

/* design/u8xml_front.sv */
// Front end: tracks the open UTF-8 sequence and turns each byte into a job.
`timescale 1ns / 1ps
module u8xml_front import u8xml_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_in_i,
  input  logic       end_of_text_i,
  output logic       job_push_o,
  output job_t       job_o
);

  logic [1:0]     need_q, need_d;
  logic [1:0]     seen_q, seen_d;
  logic [CpW-1:0] acc_q, acc_d;

  logic           is_cont;
  logic           do_fresh;
  logic [CpW-1:0] acc_n;
  logic [1:0]     seen_n;
  logic           overlong;
  logic           bad_cp;
  logic [1:0]     lead_need;
  logic [CpW-1:0] lead_bits;
  job_t           job;

  assign is_cont = (byte_in_i[7:6] == 2'b10);
  assign acc_n   = {acc_q[CpW-7:0], byte_in_i[5:0]};
  assign seen_n  = seen_q + 2'd1;

  // Check the finished value against the range of its length
  always_comb begin
    overlong = ((need_q == 2'd1) && (acc_n < CpMin2)) ||
               ((need_q == 2'd2) && (acc_n < CpMin3)) ||
               ((need_q == 2'd3) && (acc_n < CpMin4));
    bad_cp   = overlong || (acc_n > CpMax) || ((acc_n >= CpSurLo) && (acc_n <= CpSurHi));
  end

  // Decode the byte as a lead byte
  always_comb begin
    lead_need = 2'd0;
    lead_bits = '0;
    if (byte_in_i[7:5] == 3'b110) begin
      lead_need = 2'd1;
      lead_bits = {16'd0, byte_in_i[4:0]};
    end else if (byte_in_i[7:4] == 4'b1110) begin
      lead_need = 2'd2;
      lead_bits = {17'd0, byte_in_i[3:0]};
    end else if (byte_in_i[7:3] == 5'b11110) begin
      lead_need = 2'd3;
      lead_bits = {18'd0, byte_in_i[2:0]};
    end
  end

  // Next sequence state and the job for this byte
  always_comb begin
    need_d        = need_q;
    seen_d        = seen_q;
    acc_d         = acc_q;
    do_fresh      = 1'b0;
    job.n_repl    = 2'd0;
    job.has_tail  = 1'b0;
    job.tail_cp   = CpRepl;
    job.tail_ok   = 1'b0;
    job.tail_used = 3'd1;

    if (need_q == 2'd0) begin
      do_fresh = 1'b1;
    end else if (!is_cont ||
                 (end_of_text_i && ({1'b0, seen_n} < {1'b0, need_q}))) begin
      // Flush the lead and buffered continuations, then redo the byte
      job.n_repl = seen_n;
      need_d     = 2'd0;
      seen_d     = 2'd0;
      acc_d      = '0;
      do_fresh   = 1'b1;
    end else if (seen_n == need_q) begin
      job.has_tail  = 1'b1;
      job.tail_cp   = bad_cp ? CpRepl : acc_n;
      job.tail_ok   = !bad_cp;
      job.tail_used = {1'b0, need_q} + 3'd1;
      need_d        = 2'd0;
      seen_d        = 2'd0;
      acc_d         = '0;
    end else begin
      seen_d = seen_n;
      acc_d  = acc_n;
    end

    if (do_fresh) begin
      if (!byte_in_i[7]) begin
        job.has_tail = 1'b1;
        job.tail_cp  = {13'd0, byte_in_i};
        job.tail_ok  = 1'b1;
      end else if ((lead_need != 2'd0) && !end_of_text_i) begin
        need_d = lead_need;
        seen_d = 2'd0;
        acc_d  = lead_bits;
      end else begin
        job.has_tail = 1'b1;
      end
    end
  end

  assign job_o      = job;
  assign job_push_o = accept_i && ((job.n_repl != 2'd0) || job.has_tail);

  // Advance the sequence state on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      need_q <= 2'd0;
      seen_q <= 2'd0;
      acc_q  <= '0;
    end else if (accept_i) begin
      need_q <= need_d;
      seen_q <= seen_d;
      acc_q  <= acc_d;
    end
  end

endmodule

/* design/u8xml_queue.sv */
// Short job queue between the front end and the result expander.
`timescale 1ns / 1ps
module u8xml_queue import u8xml_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t head_o,
  output logic empty_o,
  output logic full_o
);

  job_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (QueuePtrW + 1)'(QueueDepth));
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + (QueuePtrW + 1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - (QueuePtrW + 1)'(1);
    end
  end

  // Hold job words; no reset needed on the payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= wr_q + QueuePtrW'(1);
      if (do_pop)  rd_q <= rd_q + QueuePtrW'(1);
      cnt_q <= cnt_d;
    end
  end

endmodule

/* design/u8xml_back.sv */
// Back end: expands each job into results, classifies them, holds the output word.
`timescale 1ns / 1ps
module u8xml_back import u8xml_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  job_t           head_i,
  input  logic           head_valid_i,
  output logic           head_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [CpW-1:0] code_point_o,
  output logic           well_formed_o,
  output logic [2:0]     bytes_used_o,
  output logic           is_xml_char_o,
  output logic           may_start_name_o,
  output logic           may_continue_name_o,
  output logic           last_of_run_o
);

  logic           out_v_q, out_v_d;
  logic [1:0]     idx_q, idx_d;
  logic           load;
  logic           emit_repl;
  logic           sel_last;
  logic [CpW-1:0] sel_cp;
  logic           sel_ok;
  logic [2:0]     sel_used;
  xml_class_t     sel_cls;

  logic [CpW-1:0] cp_q;
  logic           ok_q;
  logic [2:0]     used_q;
  xml_class_t     cls_q;
  logic           last_q;

  assign load      = head_valid_i && (!out_v_q || pop_i);
  assign emit_repl = (idx_q < head_i.n_repl);

  // Pick the next result of the head job
  always_comb begin
    if (emit_repl) begin
      sel_cp   = CpRepl;
      sel_ok   = 1'b0;
      sel_used = 3'd1;
      sel_last = ((idx_q + 2'd1) == head_i.n_repl) && !head_i.has_tail;
    end else begin
      sel_cp   = head_i.tail_cp;
      sel_ok   = head_i.tail_ok;
      sel_used = head_i.tail_used;
      sel_last = 1'b1;
    end
    sel_cls = classify(sel_cp);
  end

  assign head_pop_o = load && sel_last;

  // Advance within the job; drop it after its last result
  always_comb begin
    idx_d = idx_q;
    if (load) begin
      idx_d = sel_last ? 2'd0 : idx_q + 2'd1;
    end
    out_v_d = out_v_q;
    if (load) begin
      out_v_d = 1'b1;
    end else if (pop_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      idx_q   <= 2'd0;
    end else begin
      out_v_q <= out_v_d;
      idx_q   <= idx_d;
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= sel_cp;
      ok_q   <= sel_ok;
      used_q <= sel_used;
      cls_q  <= sel_cls;
      last_q <= sel_last;
    end
  end

  assign empty_o             = !out_v_q;
  assign code_point_o        = cp_q;
  assign well_formed_o       = ok_q;
  assign bytes_used_o        = used_q;
  assign is_xml_char_o       = cls_q.is_char;
  assign may_start_name_o    = cls_q.start;
  assign may_continue_name_o = cls_q.name;
  assign last_of_run_o       = last_q;

endmodule

/* design/utf8_decoder_xml_classifier.sv */
// Top level: UTF-8 decoder with XML 1.0 character classes.
//
//   channel | handshake         | words
//   --------+-------------------+-----------------------------------------------
//   input   | push / full       | byte_in_i, end_of_text_i
//   result  | empty / pop       | code_point_o, well_formed_o, bytes_used_o,
//           |                   | is_xml_char_o, may_start_name_o,
//           |                   | may_continue_name_o, last_of_run_o
//
// A byte is taken every cycle while the job queue (4 words) has room.
// A byte that causes k results (k = 0..4) gives one result per cycle while pop keeps up;
// its job passes through the queue and then the output word register to the ports.
// Reset clears the sequence state, the queue count and pointers and the output valid flag at once.
// A stall on pop fills the queue, then full rises; input stalls do not touch results.
`timescale 1ns / 1ps
`include "utf8_decoder_xml_classifier_assert.svh"
module utf8_decoder_xml_classifier import u8xml_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push,
  output logic           full,
  input  logic [7:0]     byte_in_i,
  input  logic           end_of_text_i,
  output logic           empty,
  input  logic           pop,
  output logic [CpW-1:0] code_point_o,
  output logic           well_formed_o,
  output logic [2:0]     bytes_used_o,
  output logic           is_xml_char_o,
  output logic           may_start_name_o,
  output logic           may_continue_name_o,
  output logic           last_of_run_o
);

  logic accept;
  logic job_push;
  job_t job;
  job_t head;
  logic q_empty;
  logic q_full;
  logic head_pop;

  assign full   = q_full;
  assign accept = push && !q_full;

  u8xml_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .byte_in_i     (byte_in_i),
    .end_of_text_i (end_of_text_i),
    .job_push_o    (job_push),
    .job_o         (job)
  );

  u8xml_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job),
    .pop_i   (head_pop),
    .head_o  (head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  u8xml_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .head_i              (head),
    .head_valid_i        (!q_empty),
    .head_pop_o          (head_pop),
    .pop_i               (pop),
    .empty_o             (empty),
    .code_point_o        (code_point_o),
    .well_formed_o       (well_formed_o),
    .bytes_used_o        (bytes_used_o),
    .is_xml_char_o       (is_xml_char_o),
    .may_start_name_o    (may_start_name_o),
    .may_continue_name_o (may_continue_name_o),
    .last_of_run_o       (last_of_run_o)
  );

  // Ill-formed input always yields the replacement character
  `U8XML_ASSERT_IMPL(a_bad_is_repl, clk_i, rst_ni, !empty && !well_formed_o,
    code_point_o == CpRepl, "ill-formed result is not U+FFFD")
  // A single-byte well-formed result is plain ASCII
  `U8XML_ASSERT_IMPL(a_one_byte_ascii, clk_i, rst_ni,
    !empty && well_formed_o && (bytes_used_o == 3'd1),
    code_point_o < CpMin2, "one-byte result above ASCII")
  // Results stay in the scalar range and use one to four bytes
  `U8XML_ASSERT_IMPL(a_result_range, clk_i, rst_ni, !empty,
    (code_point_o <= CpMax) && (bytes_used_o != 3'd0) && (bytes_used_o <= 3'd4),
    "result out of range")
  // A job is never pushed into a full queue
  `U8XML_ASSERT_IMPL(a_no_overflow, clk_i, rst_ni, q_full, !job_push,
    "job pushed into full queue")

endmodule

/* tb/u8xml_tb_pkg.sv */
// Scoreboard class with a UTF-8 decoding and XML class predictor for the decoder bench.
`timescale 1ns / 1ps
package u8xml_tb_pkg;

  import u8xml_pkg::*;

  // Leading bit patterns of UTF-8 bytes
  localparam logic [1:0] ContTag  = 2'b10;
  localparam logic [2:0] Lead2Tag = 3'b110;
  localparam logic [3:0] Lead3Tag = 4'b1110;
  localparam logic [4:0] Lead4Tag = 5'b11110;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    logic           well_formed;
    logic [2:0]     bytes_used;
    logic           is_xml_char;
    logic           may_start_name;
    logic           may_continue_name;
    logic           last_of_run;
  } cp_word_t;

  class utf8_scoreboard;
    cp_word_t       expected_cps[$];
    cp_word_t       run_words[$];
    int unsigned    mismatches;
    logic [1:0]     conts_needed;
    logic [1:0]     conts_seen;
    logic [CpW-1:0] partial_cp;

    function new();
      mismatches   = 0;
      conts_needed = '0;
      conts_seen   = '0;
      partial_cp   = '0;
    endfunction

    function int unsigned pending();
      return expected_cps.size();
    endfunction

    function bit in_span(logic [CpW-1:0] c, logic [CpW-1:0] lo, logic [CpW-1:0] hi);
      return (c >= lo) && (c <= hi);
    endfunction

    // Build a word for a code point, classify it by XML 1.0 Char, NameStartChar and NameChar, add it to the run
    function void add_word(logic [CpW-1:0] cp, logic ok, logic [2:0] used);
      cp_word_t w;
      w.code_point  = cp;
      w.well_formed = ok;
      w.bytes_used  = used;
      w.is_xml_char = (cp == 'h9) || (cp == 'hA) || (cp == 'hD) ||
                      in_span(cp, 'h20, 'hD7FF) || in_span(cp, 'hE000, 'hFFFD) ||
                      in_span(cp, 'h10000, CpMax);
      w.may_start_name = (cp == 'h3A) || (cp == 'h5F) || in_span(cp, 'h41, 'h5A) ||
                         in_span(cp, 'h61, 'h7A) || in_span(cp, 'hC0, 'hD6) ||
                         in_span(cp, 'hD8, 'hF6) || in_span(cp, 'hF8, 'h2FF) ||
                         in_span(cp, 'h370, 'h37D) || in_span(cp, 'h37F, 'h1FFF) ||
                         in_span(cp, 'h200C, 'h200D) || in_span(cp, 'h2070, 'h218F) ||
                         in_span(cp, 'h2C00, 'h2FEF) || in_span(cp, 'h3001, 'hD7FF) ||
                         in_span(cp, 'hF900, 'hFDCF) || in_span(cp, 'hFDF0, 'hFFFD) ||
                         in_span(cp, 'h10000, 'hEFFFF);
      w.may_continue_name = w.may_start_name || (cp == 'h2D) || (cp == 'h2E) ||
                            in_span(cp, 'h30, 'h39) || (cp == 'hB7) ||
                            in_span(cp, 'h300, 'h36F) || in_span(cp, 'h203F, 'h2040);
      w.last_of_run = 1'b0;
      run_words.insert(run_words.size(), w);
    endfunction

    function void clear_sequence();
      conts_needed = '0;
      conts_seen   = '0;
      partial_cp   = '0;
    endfunction

    // Decode a byte with no sequence open: ASCII, lead byte or bad lead
    function void decode_fresh(logic [7:0] b, logic eot);
      logic [1:0]     need;
      logic [CpW-1:0] bits;
      need = '0;
      bits = '0;
      if (b[7] == 1'b0) begin
        add_word(CpW'(b), 1'b1, 3'd1);
        return;
      end
      if (b[7:5] == Lead2Tag) begin
        need = 2'd1;
        bits = CpW'(b[4:0]);
      end else if (b[7:4] == Lead3Tag) begin
        need = 2'd2;
        bits = CpW'(b[3:0]);
      end else if (b[7:3] == Lead4Tag) begin
        need = 2'd3;
        bits = CpW'(b[2:0]);
      end
      // Bad lead, or a lead cut short by end of text
      if (need == 2'd0 || eot) begin
        add_word(CpRepl, 1'b0, 3'd1);
        return;
      end
      conts_needed = need;
      conts_seen   = '0;
      partial_cp   = bits;
    endfunction

    // Predict the words one accepted byte causes and queue them
    function void note_byte(logic [7:0] b, logic eot);
      logic [1:0]     buffered;
      logic [CpW-1:0] c;
      logic           bad;
      run_words.delete();
      if (conts_needed == 2'd0) begin
        decode_fresh(b, eot);
      end else if (b[7:6] != ContTag || (eot && (conts_seen + 1) < conts_needed)) begin
        // Flush the lead and any buffered continuations, then redo the byte
        buffered = conts_seen;
        add_word(CpRepl, 1'b0, 3'd1);
        for (int i = 0; i < buffered; i++) add_word(CpRepl, 1'b0, 3'd1);
        clear_sequence();
        decode_fresh(b, eot);
      end else begin
        partial_cp = {partial_cp[CpW-7:0], b[5:0]};
        conts_seen = conts_seen + 2'd1;
        if (conts_seen >= conts_needed) begin
          c   = partial_cp;
          bad = (conts_needed == 2'd1 && c < CpMin2) ||
                (conts_needed == 2'd2 && c < CpMin3) ||
                (conts_needed == 2'd3 && c < CpMin4) ||
                c > CpMax || in_span(c, CpSurLo, CpSurHi);
          if (bad) add_word(CpRepl, 1'b0, 3'(conts_needed) + 3'd1);
          else add_word(c, 1'b1, 3'(conts_needed) + 3'd1);
          clear_sequence();
        end
      end
      if (run_words.size() > 0) run_words[run_words.size()-1].last_of_run = 1'b1;
      foreach (run_words[i]) expected_cps.insert(expected_cps.size(), run_words[i]);
    endfunction

    task report(string msg);
      mismatches++;
      $display("%0t ERROR %s", $time, msg);
    endtask

    task compare_field(string field, int unsigned got, int unsigned want);
      if (got != want) report($sformatf("%s: got %0h, expected %0h", field, got, want));
    endtask

    // Check one popped word against the oldest prediction
    task check_code_point(cp_word_t got);
      cp_word_t want;
      if (expected_cps.size() == 0) begin
        report($sformatf("word cp=%0h with nothing expected", got.code_point));
        return;
      end
      want = expected_cps.pop_front();
      compare_field("code_point", got.code_point, want.code_point);
      compare_field("well_formed", got.well_formed, want.well_formed);
      compare_field("bytes_used", got.bytes_used, want.bytes_used);
      compare_field("is_xml_char", got.is_xml_char, want.is_xml_char);
      compare_field("may_start_name", got.may_start_name, want.may_start_name);
      compare_field("may_continue_name", got.may_continue_name, want.may_continue_name);
      compare_field("last_of_run", got.last_of_run, want.last_of_run);
    endtask
  endclass

endpackage

/* tb/utf8_decoder_xml_classifier_tb.sv */
// Testbench top: drives UTF-8 bytes into the decoder and checks every classified word.
`timescale 1ns / 1ps
module utf8_decoder_xml_classifier_tb;
  import u8xml_pkg::*;
  import u8xml_tb_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomBytes = 150;

  logic           clk_i;
  logic           rst_ni;
  logic           push;
  logic           full;
  logic [7:0]     byte_in_i;
  logic           end_of_text_i;
  logic           empty;
  logic           pop;
  logic [CpW-1:0] code_point_o;
  logic           well_formed_o;
  logic [2:0]     bytes_used_o;
  logic           is_xml_char_o;
  logic           may_start_name_o;
  logic           may_continue_name_o;
  logic           last_of_run_o;

  utf8_scoreboard sb;
  logic [7:0]     byte_q[$];
  logic           eot_q[$];
  int unsigned    rx_hold_cycles;
  int unsigned    tx_count;
  bit             tx_burst;

  // Code points around the XML class boundaries
  int unsigned class_edges[$] = '{'h9, 'hA, 'hD, 'h1F, 'h20, 'h2D, 'h2E, 'h30, 'h39,
    'h3A, 'h41, 'h5A, 'h5F, 'h61, 'h7A, 'h7F, 'hB7, 'hC0, 'hD6, 'hD7, 'hD8, 'hF6,
    'hF7, 'hF8, 'h2FF, 'h300, 'h36F, 'h370, 'h37D, 'h37E, 'h37F, 'h7FF, 'h1FFF,
    'h200C, 'h200D, 'h203F, 'h2040, 'h2070, 'h218F, 'h2C00, 'h2FEF, 'h3001, 'hD7FF,
    'hE000, 'hF900, 'hFDCF, 'hFDF0, 'hFFFD, 'hFFFF, 'h10000, 'hEFFFF, 'hF0000,
    'h10FFFF};

  utf8_decoder_xml_classifier u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .byte_in_i           (byte_in_i),
    .end_of_text_i       (end_of_text_i),
    .empty               (empty),
    .pop                 (pop),
    .code_point_o        (code_point_o),
    .well_formed_o       (well_formed_o),
    .bytes_used_o        (bytes_used_o),
    .is_xml_char_o       (is_xml_char_o),
    .may_start_name_o    (may_start_name_o),
    .may_continue_name_o (may_continue_name_o),
    .last_of_run_o       (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("TEST FAILED");
    $finish;
  end

  function void add_byte(logic [7:0] b, logic eot);
    byte_q.insert(byte_q.size(), b);
    eot_q.insert(eot_q.size(), eot);
  endfunction

  // Encode cp in len bytes; a len longer than needed gives an overlong form
  function void add_sequence(logic [CpW-1:0] cp, int unsigned len, logic eot_last);
    case (len)
      1: add_byte({1'b0, cp[6:0]}, eot_last);
      2: begin
        add_byte({Lead2Tag, cp[10:6]}, 1'b0);
        add_byte({ContTag, cp[5:0]}, eot_last);
      end
      3: begin
        add_byte({Lead3Tag, cp[15:12]}, 1'b0);
        add_byte({ContTag, cp[11:6]}, 1'b0);
        add_byte({ContTag, cp[5:0]}, eot_last);
      end
      default: begin
        add_byte({Lead4Tag, cp[20:18]}, 1'b0);
        add_byte({ContTag, cp[17:12]}, 1'b0);
        add_byte({ContTag, cp[11:6]}, 1'b0);
        add_byte({ContTag, cp[5:0]}, eot_last);
      end
    endcase
  endfunction

  function int unsigned min_length(int unsigned cp);
    if (cp < 'h80) return 1;
    if (cp < 'h800) return 2;
    if (cp < 'h10000) return 3;
    return 4;
  endfunction

  // Queue one random sequence: mostly well-formed text, the rest broken or noise
  function void add_random_sequence();
    int unsigned kind;
    int unsigned cp;
    int unsigned len;
    int unsigned keep;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 4))
      0: cp = $urandom_range(0, 'h7F);
      1: cp = $urandom_range('h80, 'h7FF);
      2: cp = $urandom_range('h800, 'hFFFF);
      3: cp = $urandom_range('h10000, 'h10FFFF);
      default: begin
        cp = class_edges[$urandom_range(0, class_edges.size() - 1)] + $urandom_range(0, 2) - 1;
        if (cp > CpMax) cp = CpMax;
      end
    endcase
    len = min_length(cp);
    if (kind < 60) begin
      add_sequence(CpW'(cp), len, $urandom_range(0, 9) == 0);
    end else if (kind < 70) begin
      // Overlong, surrogate or beyond the code space
      case ($urandom_range(0, 2))
        0: begin
          len = $urandom_range(2, 4);
          cp  = (len == 2) ? $urandom_range(0, 'h7F) :
                (len == 3) ? $urandom_range(0, 'h7FF) : $urandom_range(0, 'hFFFF);
        end
        1: begin
          len = 3;
          cp  = $urandom_range(CpSurLo, CpSurHi);
        end
        default: begin
          len = 4;
          cp  = $urandom_range('h110000, 'h1FFFFF);
        end
      endcase
      add_sequence(CpW'(cp), len, $urandom_range(0, 7) == 0);
    end else if (kind < 80) begin
      // Cut a multi-byte sequence short by end of text or a foreign byte
      if (len == 1) begin
        cp  = cp | 'h80;
        len = 2;
      end
      add_sequence(CpW'(cp), len, 1'b0);
      keep = $urandom_range(1, len - 1);
      repeat (len - keep) begin
        byte_q.delete(byte_q.size() - 1);
        eot_q.delete(eot_q.size() - 1);
      end
      if ($urandom_range(0, 1) == 1) eot_q[eot_q.size() - 1] = 1'b1;
      else add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 3)) begin
        add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end
    end else begin
      add_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endfunction

  // Offer one byte until accepted; entered and left at a falling edge
  task send_byte(logic [7:0] b, logic eot, int unsigned gap);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    push          <= 1'b1;
    byte_in_i     <= b;
    end_of_text_i <= eot;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    sb.note_byte(b, eot);
    @(negedge clk_i);
  endtask

  // Drain the byte queue into the block, then drop push
  task drive_bytes(bit no_gaps);
    int unsigned gap;
    logic [7:0]  b;
    logic        eot;
    while (byte_q.size() > 0) begin
      if (tx_count % 16 == 0) tx_burst = ($urandom_range(0, 2) == 0);
      gap = (no_gaps || tx_burst) ? 0 : $urandom_range(0, 9);
      b   = byte_q.pop_front();
      eot = eot_q.pop_front();
      send_byte(b, eot, gap);
      tx_count++;
    end
    push <= 1'b0;
    @(negedge clk_i);
  endtask

  task wait_drained();
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // Pop side: random stalls, bursts and one long hold on request
  initial begin : rx_side
    cp_word_t    w;
    int unsigned gap;
    int unsigned rx_count;
    bit          rx_burst;
    pop      = 1'b0;
    rx_count = 0;
    rx_burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_count % 16 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      gap = rx_burst ? 0 : $urandom_range(0, 9);
      if (rx_hold_cycles > 0) begin
        gap            = rx_hold_cycles;
        rx_hold_cycles = 0;
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
      while (empty) @(posedge clk_i);
      w.code_point        = code_point_o;
      w.well_formed       = well_formed_o;
      w.bytes_used        = bytes_used_o;
      w.is_xml_char       = is_xml_char_o;
      w.may_start_name    = may_start_name_o;
      w.may_continue_name = may_continue_name_o;
      w.last_of_run       = last_of_run_o;
      sb.check_code_point(w);
      rx_count++;
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    int unsigned random_count;
    push           = 1'b0;
    byte_in_i      = '0;
    end_of_text_i  = 1'b0;
    rst_ni         = 1'b0;
    rx_hold_cycles = 0;
    tx_count       = 0;
    tx_burst       = 1'b0;
    random_count   = 0;
    sb             = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, every sequence length and each failure kind
    add_sequence('h0, 1, 1'b0);
    add_sequence('h7F, 1, 1'b1);
    add_sequence('h80, 2, 1'b0);
    add_sequence('hFFFD, 3, 1'b0);
    add_sequence(CpMax, 4, 1'b0);
    add_sequence('h0, 2, 1'b0);         // overlong
    add_sequence(CpSurHi, 3, 1'b0);     // surrogate
    add_sequence('h1FFFFF, 4, 1'b0);    // beyond the code space
    add_byte('h80, 1'b0);               // stray continuation
    add_byte('hFF, 1'b0);               // bad lead
    add_byte('hC3, 1'b1);               // lead byte at end of text
    add_byte('hF0, 1'b0);               // truncation at end of text
    add_byte('h90, 1'b0);
    add_byte('h80, 1'b1);
    add_byte('hE2, 1'b0);               // broken by an ASCII byte
    add_byte('h41, 1'b0);
    drive_bytes(1'b0);
    wait_drained();

    // Hold the pop side while bytes keep coming, so the input stalls
    rx_hold_cycles = 200;
    repeat (30) add_byte(8'($urandom_range(0, 'h7F)), 1'b0);
    drive_bytes(1'b1);
    wait_drained();

    // Random text with occasional full drains
    while (random_count < RandomBytes) begin
      add_random_sequence();
      random_count += byte_q.size();
      drive_bytes(1'b0);
      if ($urandom_range(0, 24) == 0) wait_drained();
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (sb.mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
